// File: hw/rtl/tpcs_pkg.sv
// package for the tag profile cosine similarity unit
// holds default sizes and request codes; no dependencies
`default_nettype none
package tpcs_pkg;
  localparam int unsigned NumProfilesDef = 64;
  localparam int unsigned NumTagsDef     = 12;
  localparam int unsigned CountBitsDef   = 12;
  localparam int unsigned ProfBits       = 6;
  localparam int unsigned TagBits        = 4;
  localparam int unsigned SimBits        = 17;
  localparam logic ReqAdd     = 1'b0;
  localparam logic ReqCompare = 1'b1;
endpackage
`default_nettype wire

// File: hw/rtl/tag_profile_cosine_similarity_unit.sv
// top level of the tag profile cosine similarity unit
// uses tpcs_pkg and tpcs_divsqrt
`default_nettype none
// usage:
// an item is taken at a clock edge with start high and busy low.
// req_type_i add: raise bin tag_code_i of profile_a_i (saturating); codes at or
// above the tag count are ignored and give an all-zero result.
// req_type_i compare: cosine similarity of profile_a_i and profile_b_i with
// 16 fraction bits, clamped to 1.0; an empty profile gives 0 and zero_length_o.
// each item gives one result, shown for a single cycle with done_o high;
// the receiver cannot stall, so results are never held.
// an add reads its bin, then writes it back raised; an ignored tag gives its
// result straight from idle. a compare reads and accumulates each bin pair
// through the single memory port, then runs the shared shift-add, root and
// divide unit; when a profile is empty the result is given without that unit.
// busy is high from accept through the result cycle; one item at a time, the
// next item is taken in the cycle after the result at the earliest.
// after reset a clearing pass writes zero to every bin (NUM_PROFILES*NUM_TAGS,
// 768 by default), one entry per cycle, with busy high.
module tag_profile_cosine_similarity_unit #(
  parameter int unsigned NUM_PROFILES = tpcs_pkg::NumProfilesDef,
  parameter int unsigned NUM_TAGS     = tpcs_pkg::NumTagsDef,
  parameter int unsigned COUNT_BITS   = tpcs_pkg::CountBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          req_type_i,
  input  wire logic [tpcs_pkg::ProfBits-1:0] profile_a_i,
  input  wire logic [tpcs_pkg::ProfBits-1:0] profile_b_i,
  input  wire logic [tpcs_pkg::TagBits-1:0]  tag_code_i,
  output logic                               done_o,
  output logic [tpcs_pkg::SimBits-1:0]       similarity_o,
  output logic [11:0]                        count_after_o,
  output logic                               zero_length_o
);
  import tpcs_pkg::*;

  localparam int unsigned Depth   = NUM_PROFILES * NUM_TAGS;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned PW      = $clog2(NUM_PROFILES) > 0 ? $clog2(NUM_PROFILES) : 1;
  localparam int unsigned TW      = $clog2(NUM_TAGS + 1);
  localparam int unsigned SqW     = 2 * COUNT_BITS;
  localparam int unsigned SumBits = SqW + $clog2(NUM_TAGS + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StAddRd = 3'd2;
  localparam logic [2:0] StAddWr = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StMac   = 3'd5;
  localparam logic [2:0] StCalc  = 3'd6;
  localparam logic [2:0] StOut   = 3'd7;

  // profile index reduced modulo NUM_PROFILES by compare and subtract
  function automatic logic [ProfBits-1:0] prof_mod(logic [ProfBits-1:0] p);
    logic [31:0] r;
    r = 32'(p);
    for (int k = ProfBits - 1; k >= 0; k--) begin
      if (r >= (32'(NUM_PROFILES) << k)) r = r - (32'(NUM_PROFILES) << k);
    end
    return ProfBits'(r);
  endfunction

  logic [COUNT_BITS-1:0] mem_q [Depth];
  logic [COUNT_BITS-1:0] rdata_q;
  logic [AddrW-1:0]      raddr, waddr;
  logic                  we;
  logic [COUNT_BITS-1:0] wdata;

  logic [2:0]            st_q, st_d;
  logic [AddrW:0]        clr_q, clr_d;
  logic                  req_q;
  logic [PW-1:0]         pa_q, pb_q;
  logic [TW-1:0]         idx_q, idx_d;
  logic                  side_q, side_d;
  logic [COUNT_BITS-1:0] a_q, a_d;
  logic [SumBits-1:0]    sa_q, sa_d, sb_q, sb_d, dot_q, dot_d;
  logic [SqW-1:0]        prod_q, prod_d;
  logic [1:0]            mac_sel_q, mac_sel_d;
  logic                  res_v_q, res_v_d;
  logic [SimBits-1:0]    sim_q, sim_d;
  logic [11:0]           cnt_q, cnt_d;
  logic                  zero_q, zero_d;
  logic                  go;
  logic                  dv_done;
  logic [SimBits-1:0]    dv_sim;
  logic [COUNT_BITS-1:0] inc;
  logic [PW-1:0]         pa_in, pb_in;
  logic                  accept;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  assign accept = start && !busy;
  assign pa_in = PW'(prof_mod(profile_a_i));
  assign pb_in = PW'(prof_mod(profile_b_i));
  assign inc   = (rdata_q == CountMax) ? rdata_q : rdata_q + 1'b1;

  always_comb begin
    raddr = '0;
    if (st_q == StIdle) raddr = AddrW'(pa_in * NUM_TAGS + tag_code_i);
    else if (st_q == StRead || st_q == StMac)
      raddr = AddrW'((side_q ? pb_q : pa_q) * NUM_TAGS + idx_q);
    else raddr = AddrW'(pa_q * NUM_TAGS + idx_q);
  end

  always_comb begin
    st_d = st_q; clr_d = clr_q; idx_d = idx_q; side_d = side_q; a_d = a_q;
    sa_d = sa_q; sb_d = sb_q; dot_d = dot_q; prod_d = prod_q; mac_sel_d = 2'd0;
    res_v_d = 1'b0; sim_d = sim_q; cnt_d = cnt_q; zero_d = zero_q;
    we = 1'b0; waddr = AddrW'(pa_q * NUM_TAGS + idx_q); wdata = inc; go = 1'b0;
    case (st_q)
      StClear: begin
        we = 1'b1; waddr = clr_q[AddrW-1:0]; wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (AddrW+1)'(Depth - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          idx_d = TW'(tag_code_i); side_d = 1'b0;
          sa_d = '0; sb_d = '0; dot_d = '0;
          if (req_type_i == ReqCompare) begin
            st_d = StRead; idx_d = '0;
          end else if ({1'b0, tag_code_i} < (TagBits+1)'(NUM_TAGS)) st_d = StAddRd;
          else begin
            res_v_d = 1'b1; sim_d = '0; cnt_d = '0; zero_d = 1'b0;
          end
        end
      end
      StAddRd: st_d = StAddWr;
      StAddWr: begin
        we = 1'b1; res_v_d = 1'b1; sim_d = '0; zero_d = 1'b0;
        cnt_d = 12'(inc); st_d = StIdle;
      end
      StRead: begin
        // alternate a bin then b bin; a read issued here lands next cycle
        st_d = StMac; mac_sel_d = side_q ? 2'd2 : 2'd1;
      end
      StMac: begin
        if (mac_sel_q == 2'd1) begin
          a_d = rdata_q; prod_d = rdata_q * rdata_q; mac_sel_d = 2'd3;
        end else if (mac_sel_q == 2'd2) begin
          prod_d = rdata_q * rdata_q; mac_sel_d = 2'd0;
          sb_d = sb_q; dot_d = dot_q;
        end
        // accumulate the product registered last cycle
        case (mac_sel_q)
          2'd3: begin
            sa_d = sa_q + SumBits'(prod_q);
            side_d = 1'b1; st_d = StRead;
          end
          2'd0: begin
            sb_d = sb_q + SumBits'(prod_q);
            prod_d = a_q * rdata_q;
            mac_sel_d = 2'd0;
          end
          default: ;
        endcase
        if (mac_sel_q == 2'd2) begin
          st_d = StMac; mac_sel_d = 2'd0;
        end else if (mac_sel_q == 2'd0) begin
          st_d = StOut;
        end
      end
      StOut: begin
        // dot term, then next bin or finish
        dot_d = dot_q + SumBits'(prod_q); side_d = 1'b0;
        if (idx_q == TW'(NUM_TAGS - 1)) begin
          if (sa_q == '0 || sb_q == '0) begin
            res_v_d = 1'b1; sim_d = '0; cnt_d = '0; zero_d = 1'b1; st_d = StIdle;
          end else begin
            st_d = StCalc; go = 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1; st_d = StRead;
        end
      end
      StCalc: begin
        if (dv_done) begin
          res_v_d = 1'b1; sim_d = dv_sim; cnt_d = '0; zero_d = 1'b0; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0; res_v_q <= 1'b0; mac_sel_q <= 2'd0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; res_v_q <= res_v_d; mac_sel_q <= mac_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && accept) begin
      req_q <= req_type_i; pa_q <= pa_in; pb_q <= pb_in;
    end
    idx_q <= idx_d; side_q <= side_d; a_q <= a_d; sa_q <= sa_d; sb_q <= sb_d;
    dot_q <= dot_d; prod_q <= prod_d; sim_q <= sim_d; cnt_q <= cnt_d;
    zero_q <= zero_d;
  end

  tpcs_divsqrt #(.SumBits(SumBits), .DotBits(SumBits)) u_divsqrt (
    .clk_i, .rst_ni, .go_i(go), .sa_i(sa_d), .sb_i(sb_q), .dot_i(dot_d),
    .done_o(dv_done), .sim_o(dv_sim)
  );

  assign busy          = (st_q != StIdle) || res_v_q;
  assign done_o        = res_v_q;
  assign similarity_o  = sim_q;
  assign count_after_o = cnt_q;
  assign zero_length_o = zero_q;

`ifndef SYNTH
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |=> !res_v_q) else $error("double result");
  a_add_no_sim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !req_q) |-> similarity_o == '0) else $error("add sim");
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && zero_q) |-> similarity_o == '0) else $error("zero flag");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/tpcs_divsqrt.sv
// shared iterative unit: floor(sqrt(x*y)) then floor(dot*2^16/den), clamped
// uses tpcs_pkg; one bit per cycle in each phase: multiplier, root and quotient
`default_nettype none
module tpcs_divsqrt #(
  parameter int unsigned SumBits = 28,
  parameter int unsigned DotBits = 28
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         go_i,
  input  wire logic [SumBits-1:0]           sa_i,
  input  wire logic [SumBits-1:0]           sb_i,
  input  wire logic [DotBits-1:0]           dot_i,
  output logic                              done_o,
  output logic [tpcs_pkg::SimBits-1:0]      sim_o
);
  import tpcs_pkg::*;

  localparam int unsigned PBits = 2 * SumBits;
  localparam int unsigned RBits = SumBits;
  localparam int unsigned NBits = DotBits + 16;
  localparam int unsigned CntW  = $clog2(NBits + 1);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StSqrt = 2'd2;
  localparam logic [1:0] StDiv  = 2'd3;

  logic [1:0]       st_q, st_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PBits-1:0] prod_q, prod_d;
  logic [PBits-1:0] rem_q, rem_d;
  logic [RBits-1:0] root_q, root_d;
  logic [NBits-1:0] num_q, num_d;
  logic [NBits:0]   drem_q, drem_d;
  logic [NBits-1:0] quo_q, quo_d;
  logic [SumBits-1:0] mulb_q, mulb_d;
  logic [PBits-1:0] mula_q, mula_d;
  logic             done_d, done_q;

  // restoring square root, two radicand bits per step
  logic [PBits+1:0] s_rem, s_trial;
  logic [NBits:0]   d_shift;
  logic [NBits:0]   den_ext;

  always_comb begin
    s_rem   = {rem_q, prod_q[PBits-1 -: 2]};
    s_trial = {{(PBits-RBits){1'b0}}, root_q, 2'b01};
    d_shift = {drem_q[NBits-1:0], num_q[NBits-1]};
    den_ext = (root_q == '0) ? {{NBits{1'b0}}, 1'b1}
                             : {{(NBits+1-RBits){1'b0}}, root_q};
  end

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; prod_d = prod_q; rem_d = rem_q; root_d = root_q;
    num_d = num_q; drem_d = drem_q; quo_d = quo_q; mula_d = mula_q;
    mulb_d = mulb_q; done_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (go_i) begin
          st_d   = StMul;
          mula_d = {{SumBits{1'b0}}, sa_i};
          mulb_d = sb_i;
          prod_d = '0;
          num_d  = {dot_i, 16'd0};
          cnt_d  = CntW'(SumBits);
        end
      end
      StMul: begin
        // shift-add product, one multiplier bit per cycle
        if (mulb_q[0]) prod_d = prod_q + mula_q;
        mula_d = mula_q << 1;
        mulb_d = mulb_q >> 1;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          st_d = StSqrt; cnt_d = CntW'(RBits); rem_d = '0; root_d = '0;
        end
      end
      StSqrt: begin
        prod_d = prod_q << 2;
        if (s_rem >= s_trial) begin
          rem_d  = PBits'(s_rem - s_trial);
          root_d = {root_q[RBits-2:0], 1'b1};
        end else begin
          rem_d  = PBits'(s_rem);
          root_d = {root_q[RBits-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          st_d = StDiv; cnt_d = CntW'(NBits); drem_d = '0; quo_d = '0;
        end
      end
      StDiv: begin
        num_d = num_q << 1;
        if (d_shift >= den_ext) begin
          drem_d = d_shift - den_ext;
          quo_d  = {quo_q[NBits-2:0], 1'b1};
        end else begin
          drem_d = d_shift;
          quo_d  = {quo_q[NBits-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          st_d = StIdle; done_d = 1'b1;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d; rem_q <= rem_d; root_q <= root_d; num_q <= num_d;
    drem_q <= drem_d; quo_q <= quo_d; mula_q <= mula_d; mulb_q <= mulb_d;
  end

  assign done_o = done_q;
  assign sim_o  = (quo_q > NBits'(65536)) ? SimBits'(65536) : SimBits'(quo_q);

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go_i && st_q == StIdle) |=> st_q == StMul) else $error("no start");
  a_sim_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> sim_o <= SimBits'(65536)) else $error("clamp");
`endif
endmodule
`default_nettype wire
